// ===== src/aas_pkg.sv =====
// Shared types, codes and constants of the alarm annunciator sequencer.
package aas_pkg;

	// Request codes carried by req_type
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_APPLY = 2'd1,
		REQ_CHIRP = 2'd2,
		REQ_LED   = 2'd3
	} req_t;

	// Panel modes
	typedef enum logic [1:0] {
		MODE_DISARMED  = 2'd0,
		MODE_ARMED     = 2'd1,
		MODE_PREALARM  = 2'd2,
		MODE_TRIGGERED = 2'd3
	} mode_t;

	// Buzzer sequence modes
	typedef enum logic [1:0] {
		BZ_OFF   = 2'd0,
		BZ_ENTRY = 2'd1,
		BZ_CHIRP = 2'd2,
		BZ_SIREN = 2'd3
	} bz_mode_t;

	// LED actions reported in a result
	typedef enum logic [1:0] {
		LED_NONE = 2'd0,
		LED_ALL  = 2'd1,
		LED_ONE  = 2'd2
	} led_act_t;

	// Buzzer actions reported in a result
	typedef enum logic [1:0] {
		BZA_NONE    = 2'd0,
		BZA_TONE    = 2'd1,
		BZA_SILENCE = 2'd2
	} bz_act_t;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EXIT_DELAY = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_EN   = 1'd1;

	localparam logic [31:0] EXIT_DELAY_RST = 32'd30000;

	// Timing in milliseconds
	localparam logic [31:0] LED_PULSE_MS    = 32'd400;
	localparam logic [31:0] ENTRY_BEEP_MS   = 32'd200;
	localparam logic [31:0] SIREN_SWAP_MS   = 32'd500;
	localparam int unsigned CHIRP_PERIOD_MS = 1000;
	localparam logic [9:0]  CHIRP_ON_MS     = 10'd100;

	// Tones in Hz
	localparam logic [9:0] TONE_ENTRY  = 10'd440;
	localparam logic [9:0] TONE_HIGH   = 10'd880;
	localparam logic [9:0] TONE_LOW    = 10'd660;
	localparam logic [9:0] TONE_CHIRP  = 10'd1000;

	// Defaults of the top-level parameters
	localparam int unsigned LED_COUNT_DEF = 5;
	localparam int unsigned TIME_BITS_DEF = 32;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	localparam rgb_t COL_DISARMED = '{red: 8'd0,   green: 8'd20, blue: 8'd0};
	localparam rgb_t COL_ARMED    = '{red: 8'd0,   green: 8'd0,  blue: 8'd180};
	localparam rgb_t COL_PRE      = '{red: 8'd255, green: 8'd80, blue: 8'd0};
	localparam rgb_t COL_PRE_DIM  = '{red: 8'd100, green: 8'd30, blue: 8'd0};
	localparam rgb_t COL_TRIG     = '{red: 8'd255, green: 8'd0,  blue: 8'd0};
	localparam rgb_t COL_TRIG_DIM = '{red: 8'd80,  green: 8'd0,  blue: 8'd0};

	// One result transaction
	typedef struct packed {
		led_act_t   led_action;
		logic [2:0] led_target;
		rgb_t       colour;
		bz_act_t    buzzer_action;
		logic [9:0] tone_hz;
	} res_t;

	// Residues of 2^10, 2^20 and 2^30 modulo the chirp period
	localparam logic [19:0] FOLD_10 = 20'((2**10) % CHIRP_PERIOD_MS);
	localparam logic [19:0] FOLD_20 = 20'((2**20) % CHIRP_PERIOD_MS);
	localparam logic [19:0] FOLD_30 = 20'((2**30) % CHIRP_PERIOD_MS);

	// Position within the chirp period: fold 10-bit digits by their residues,
	// then one compare and subtract
	function automatic logic [9:0] chirp_phase(input logic [31:0] v);
		logic [19:0] f1;
		logic [14:0] f2;
		logic [10:0] f3;
		f1 = 20'(v[9:0]) + 20'(v[19:10]) * FOLD_10 + 20'(v[29:20]) * FOLD_20
			+ 20'(v[31:30]) * FOLD_30;
		f2 = 15'(f1[9:0]) + 15'(f1[19:10]) * 15'(FOLD_10);
		f3 = 11'(f2[9:0]) + 11'(f2[14:10]) * 11'(FOLD_10);
		if (f3 >= 11'(CHIRP_PERIOD_MS)) begin
			f3 = f3 - 11'(CHIRP_PERIOD_MS);
		end
		return f3[9:0];
	endfunction

endpackage

// ===== src/alarm_annunciator_sequencer.sv =====
// Alarm annunciator sequencer: LED strip and buzzer sequencing for an alarm panel.
//
// Usage: requests enter on the in channel (in_valid/in_ready) with the current
// millisecond time; each request gives exactly one result on the out channel
// (out_valid/out_ready) telling the LED driver and buzzer what to change.
// Configuration (exit delay, LED pulsing) is written on the cfg channel, which
// is always ready; write it only while no request is in flight.
// The input register holds an accepted request, and its result is loaded into
// the output register as the request leaves the input register, which it does
// as soon as the output register is free or its result is being taken.
// Throughput: one request per cycle while the receiver takes results, set by
// the single combinational pass from the input register through the state
// update to the result register; the chirp phase within its 1000 ms period
// comes from a digit-folding residue. When the receiver stalls, the result
// waits in the output register and one more request is taken into the input
// register; in_ready then drops until the result is taken.
// Reset: panel disarmed, buzzer off, LEDs marked bright, exit delay 30000 ms,
// pulsing enabled, both channels empty.
module alarm_annunciator_sequencer #(
	parameter int unsigned LED_COUNT = aas_pkg::LED_COUNT_DEF,
	parameter int unsigned TIME_BITS = aas_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [aas_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [31:0]                       cfg_data,
	// requests
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        req_type,
	input  logic [TIME_BITS-1:0]              now_ms,
	input  logic [1:0]                        new_state,
	input  logic [2:0]                        led_select,
	input  logic [7:0]                        red_in,
	input  logic [7:0]                        green_in,
	input  logic [7:0]                        blue_in,
	// results
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        led_action,
	output logic [2:0]                        led_target,
	output logic [7:0]                        red_out,
	output logic [7:0]                        green_out,
	output logic [7:0]                        blue_out,
	output logic [1:0]                        buzzer_action,
	output logic [9:0]                        tone_hz
);

	// configuration registers
	logic [31:0] exit_delay_q;
	logic        pulse_en_q;

	// input register
	logic                   s1_valid_q;
	aas_pkg::req_t          req_s1;
	logic [TIME_BITS-1:0]   now_s1;
	aas_pkg::mode_t         state_s1;
	logic [2:0]             sel_s1;
	aas_pkg::rgb_t          rgb_s1;

	// sequencer state
	aas_pkg::mode_t         mode_q, mode_d;
	logic [TIME_BITS-1:0]   led_mark_q, led_mark_d;
	logic                   bright_q, bright_d;
	aas_pkg::bz_mode_t      bz_mode_q, bz_mode_d;
	logic                   bz_on_q, bz_on_d;
	logic [TIME_BITS-1:0]   bz_mark_q, bz_mark_d;
	logic [TIME_BITS-1:0]   chirp_start_q, chirp_start_d;
	logic                   siren_high_q, siren_high_d;

	// result register
	logic                   out_valid_q;
	aas_pkg::res_t          res_q, res_d;

	logic                   in_take;
	logic                   adv;
	logic [TIME_BITS-1:0]   led_el, bz_el, chirp_el;
	logic [9:0]             phase;

	// handshake: the input register moves on when the output register frees
	assign adv       = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready  = !s1_valid_q || adv;
	assign in_take   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exit_delay_q <= aas_pkg::EXIT_DELAY_RST;
			pulse_en_q   <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				aas_pkg::CFG_EXIT_DELAY: exit_delay_q <= cfg_data;
				aas_pkg::CFG_PULSE_EN:   pulse_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// hold the accepted transaction in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_take) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1       <= aas_pkg::req_t'(req_type);
			now_s1       <= now_ms;
			state_s1     <= aas_pkg::mode_t'(new_state);
			sel_s1       <= led_select;
			rgb_s1.red   <= red_in;
			rgb_s1.green <= green_in;
			rgb_s1.blue  <= blue_in;
		end
	end

	// elapsed times, wrapping at the time width
	assign led_el   = now_s1 - led_mark_q;
	assign bz_el    = now_s1 - bz_mark_q;
	assign chirp_el = now_s1 - chirp_start_q;
	assign phase    = aas_pkg::chirp_phase(32'(chirp_el));

	// next state and result for the transaction in the input register
	always_comb begin
		mode_d        = mode_q;
		led_mark_d    = led_mark_q;
		bright_d      = bright_q;
		bz_mode_d     = bz_mode_q;
		bz_on_d       = bz_on_q;
		bz_mark_d     = bz_mark_q;
		chirp_start_d = chirp_start_q;
		siren_high_d  = siren_high_q;
		res_d         = '0;

		case (req_s1)
			aas_pkg::REQ_APPLY: begin
				mode_d              = state_s1;
				bright_d            = 1'b1;
				led_mark_d          = now_s1;
				bz_on_d             = 1'b0;
				bz_mode_d           = aas_pkg::BZ_OFF;
				chirp_start_d       = '0;
				res_d.led_action    = aas_pkg::LED_ALL;
				res_d.buzzer_action = aas_pkg::BZA_SILENCE;
				case (state_s1)
					aas_pkg::MODE_DISARMED: res_d.colour = aas_pkg::COL_DISARMED;
					aas_pkg::MODE_ARMED:    res_d.colour = aas_pkg::COL_ARMED;
					aas_pkg::MODE_PREALARM: begin
						res_d.colour        = aas_pkg::COL_PRE;
						res_d.buzzer_action = aas_pkg::BZA_TONE;
						res_d.tone_hz       = aas_pkg::TONE_ENTRY;
						bz_mode_d           = aas_pkg::BZ_ENTRY;
						bz_mark_d           = now_s1;
					end
					default: begin
						res_d.colour        = aas_pkg::COL_TRIG;
						res_d.buzzer_action = aas_pkg::BZA_TONE;
						res_d.tone_hz       = aas_pkg::TONE_HIGH;
						bz_on_d             = 1'b1;
						bz_mode_d           = aas_pkg::BZ_SIREN;
						bz_mark_d           = now_s1;
						siren_high_d        = 1'b1;
					end
				endcase
			end
			aas_pkg::REQ_CHIRP: begin
				chirp_start_d       = now_s1;
				bz_mode_d           = aas_pkg::BZ_CHIRP;
				bz_on_d             = 1'b1;
				res_d.buzzer_action = aas_pkg::BZA_TONE;
				res_d.tone_hz       = aas_pkg::TONE_CHIRP;
			end
			aas_pkg::REQ_LED: begin
				if ({1'b0, sel_s1} < 4'(LED_COUNT)) begin
					res_d.led_action = aas_pkg::LED_ONE;
					res_d.led_target = sel_s1;
					res_d.colour     = rgb_s1;
				end
			end
			default: begin
				// pulse the LEDs in the alarm modes
				if (pulse_en_q && (mode_q == aas_pkg::MODE_PREALARM ||
						mode_q == aas_pkg::MODE_TRIGGERED) &&
						32'(led_el) >= aas_pkg::LED_PULSE_MS) begin
					led_mark_d       = now_s1;
					bright_d         = !bright_q;
					res_d.led_action = aas_pkg::LED_ALL;
					if (mode_q == aas_pkg::MODE_PREALARM) begin
						res_d.colour = bright_d ? aas_pkg::COL_PRE : aas_pkg::COL_PRE_DIM;
					end else begin
						res_d.colour = bright_d ? aas_pkg::COL_TRIG : aas_pkg::COL_TRIG_DIM;
					end
				end
				// advance the buzzer sequence
				case (bz_mode_q)
					aas_pkg::BZ_ENTRY: begin
						if (32'(bz_el) >= aas_pkg::ENTRY_BEEP_MS) begin
							res_d.buzzer_action = aas_pkg::BZA_SILENCE;
							bz_mode_d           = aas_pkg::BZ_OFF;
							bz_on_d             = 1'b0;
						end
					end
					aas_pkg::BZ_CHIRP: begin
						if (32'(chirp_el) >= exit_delay_q) begin
							res_d.buzzer_action = aas_pkg::BZA_SILENCE;
							bz_on_d             = 1'b0;
							bz_mode_d           = aas_pkg::BZ_OFF;
							chirp_start_d       = '0;
						end else if (phase < aas_pkg::CHIRP_ON_MS && !bz_on_q) begin
							res_d.buzzer_action = aas_pkg::BZA_TONE;
							res_d.tone_hz       = aas_pkg::TONE_CHIRP;
							bz_on_d             = 1'b1;
						end else if (phase >= aas_pkg::CHIRP_ON_MS && bz_on_q) begin
							res_d.buzzer_action = aas_pkg::BZA_SILENCE;
							bz_on_d             = 1'b0;
						end
					end
					aas_pkg::BZ_SIREN: begin
						if (32'(bz_el) >= aas_pkg::SIREN_SWAP_MS) begin
							bz_mark_d           = now_s1;
							siren_high_d        = !siren_high_q;
							res_d.buzzer_action = aas_pkg::BZA_TONE;
							res_d.tone_hz       = siren_high_d ? aas_pkg::TONE_HIGH
								: aas_pkg::TONE_LOW;
						end
					end
					default: ;
				endcase
			end
		endcase
	end

	// commit state as the transaction leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= aas_pkg::MODE_DISARMED;
			led_mark_q    <= '0;
			bright_q      <= 1'b1;
			bz_mode_q     <= aas_pkg::BZ_OFF;
			bz_on_q       <= 1'b0;
			bz_mark_q     <= '0;
			chirp_start_q <= '0;
			siren_high_q  <= 1'b1;
		end else if (adv) begin
			mode_q        <= mode_d;
			led_mark_q    <= led_mark_d;
			bright_q      <= bright_d;
			bz_mode_q     <= bz_mode_d;
			bz_on_q       <= bz_on_d;
			bz_mark_q     <= bz_mark_d;
			chirp_start_q <= chirp_start_d;
			siren_high_q  <= siren_high_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign led_action    = res_q.led_action;
	assign led_target    = res_q.led_target;
	assign red_out       = res_q.colour.red;
	assign green_out     = res_q.colour.green;
	assign blue_out      = res_q.colour.blue;
	assign buzzer_action = res_q.buzzer_action;
	assign tone_hz       = res_q.tone_hz;

	// a held transaction is never dropped while the output is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !adv |=> s1_valid_q)
		else $error("input register lost a transaction");

	// a single-LED write only ever targets an existing LED
	a_led_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.led_action == aas_pkg::LED_ONE |->
			{1'b0, res_q.led_target} < 4'(LED_COUNT))
		else $error("single-LED write beyond the strip");

	// the buzzer is only marked on while a sequence is running
	a_bz_on_mode: assert property (@(posedge clk) disable iff (!arst_n)
		bz_on_q |-> bz_mode_q != aas_pkg::BZ_OFF)
		else $error("buzzer on with no sequence");

	// a tone is reported only with a sound action
	a_tone_action: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.buzzer_action != aas_pkg::BZA_TONE |-> res_q.tone_hz == '0)
		else $error("tone reported without sound action");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the alarm annunciator sequencer.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import aas_pkg::*;

	// One request as presented on the in channel
	typedef struct packed {
		req_t       kind;
		logic [31:0] now;
		mode_t      state;
		logic [2:0] sel;
		rgb_t       colour;
	} panel_req_t;

	// One row of the directed plan; a register write carries its index in sel
	// and its data in word
	typedef struct packed {
		logic       cfg;
		logic       typed;
		req_t       kind;
		logic [31:0] word;
		mode_t      state;
		logic [2:0] sel;
		rgb_t       colour;
		res_t       result;
	} step_t;

	localparam rgb_t FULL  = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};
	localparam rgb_t DARK  = '0;
	localparam res_t QUIET = '0;

	localparam step_t PLAN [27] = '{
		// single-LED writes: both ends of the strip, indices past the end
		'{1'b0, 1'b1, REQ_LED, 32'd0, MODE_DISARMED, 3'd0, FULL,
			'{LED_ONE, 3'd0, FULL, BZA_NONE, 10'd0}},
		'{1'b0, 1'b1, REQ_LED, 32'hFFFF_FFFF, MODE_ARMED, 3'd4, DARK,
			'{LED_ONE, 3'd4, DARK, BZA_NONE, 10'd0}},
		'{1'b0, 1'b1, REQ_LED, 32'd7, MODE_TRIGGERED, 3'd5, '{8'h0F, 8'hF0, 8'h5A},
			QUIET},
		'{1'b0, 1'b1, REQ_LED, 32'd9, MODE_PREALARM, 3'd7, '{8'hA5, 8'h5A, 8'hC3},
			QUIET},
		'{1'b0, 1'b1, REQ_LED, 32'd11, MODE_DISARMED, 3'd3, '{8'hF0, 8'h0F, 8'hA5},
			'{LED_ONE, 3'd3, '{8'hF0, 8'h0F, 8'hA5}, BZA_NONE, 10'd0}},
		// idle tick with the panel still in its reset state
		'{1'b0, 1'b1, REQ_TICK, 32'd0, MODE_DISARMED, 3'd0, DARK, QUIET},
		// disarmed, armed and pre-alarm states, entry beep ending and pulse across the time wrap
		'{1'b0, 1'b1, REQ_APPLY, 32'd100, MODE_DISARMED, 3'd0, DARK,
			'{LED_ALL, 3'd0, COL_DISARMED, BZA_SILENCE, 10'd0}},
		'{1'b0, 1'b1, REQ_APPLY, 32'd200, MODE_ARMED, 3'd0, DARK,
			'{LED_ALL, 3'd0, COL_ARMED, BZA_SILENCE, 10'd0}},
		'{1'b0, 1'b1, REQ_APPLY, 32'hFFFF_FF00, MODE_PREALARM, 3'd0, DARK,
			'{LED_ALL, 3'd0, COL_PRE, BZA_TONE, TONE_ENTRY}},
		'{1'b0, 1'b0, REQ_TICK, 32'hFFFF_FF96, MODE_DISARMED, 3'd0, DARK, QUIET},
		'{1'b0, 1'b0, REQ_TICK, 32'h0000_0010, MODE_DISARMED, 3'd0, DARK, QUIET},
		'{1'b0, 1'b0, REQ_TICK, 32'h0000_0090, MODE_DISARMED, 3'd0, DARK, QUIET},
		// siren: LED pulse and tone swap in one result, then pulse alone
		'{1'b0, 1'b1, REQ_APPLY, 32'd1000, MODE_TRIGGERED, 3'd0, DARK,
			'{LED_ALL, 3'd0, COL_TRIG, BZA_TONE, TONE_HIGH}},
		'{1'b0, 1'b0, REQ_TICK, 32'd1500, MODE_DISARMED, 3'd0, DARK, QUIET},
		'{1'b0, 1'b0, REQ_TICK, 32'd1999, MODE_DISARMED, 3'd0, DARK, QUIET},
		// arming chirp over the time wrap, through to the end of the exit delay
		'{1'b0, 1'b1, REQ_APPLY, 32'd2000, MODE_ARMED, 3'd0, DARK,
			'{LED_ALL, 3'd0, COL_ARMED, BZA_SILENCE, 10'd0}},
		'{1'b0, 1'b1, REQ_CHIRP, 32'hFFFF_FFF0, MODE_DISARMED, 3'd0, DARK,
			'{LED_NONE, 3'd0, DARK, BZA_TONE, TONE_CHIRP}},
		'{1'b0, 1'b0, REQ_TICK, 32'h0000_0050, MODE_DISARMED, 3'd0, DARK, QUIET},
		'{1'b0, 1'b0, REQ_TICK, 32'h0000_0060, MODE_DISARMED, 3'd0, DARK, QUIET},
		'{1'b0, 1'b0, REQ_TICK, 32'd984, MODE_DISARMED, 3'd0, DARK, QUIET},
		'{1'b0, 1'b0, REQ_TICK, 32'd29984, MODE_DISARMED, 3'd0, DARK, QUIET},
		// zero exit delay with pulsing off
		'{1'b1, 1'b0, REQ_TICK, 32'd0, MODE_DISARMED, 3'(CFG_EXIT_DELAY), DARK, QUIET},
		'{1'b1, 1'b0, REQ_TICK, 32'd0, MODE_DISARMED, 3'(CFG_PULSE_EN), DARK, QUIET},
		'{1'b0, 1'b1, REQ_APPLY, 32'd40000, MODE_TRIGGERED, 3'd0, DARK,
			'{LED_ALL, 3'd0, COL_TRIG, BZA_TONE, TONE_HIGH}},
		'{1'b0, 1'b1, REQ_CHIRP, 32'd40000, MODE_DISARMED, 3'd0, DARK,
			'{LED_NONE, 3'd0, DARK, BZA_TONE, TONE_CHIRP}},
		'{1'b0, 1'b0, REQ_TICK, 32'd40000, MODE_DISARMED, 3'd0, DARK, QUIET},
		'{1'b0, 1'b0, REQ_TICK, 32'd41000, MODE_DISARMED, 3'd0, DARK, QUIET}
	};

	// Register settings of the random phases
	localparam logic [31:0] DELAYS [4] = '{32'd2500, 32'hFFFF_FFFF, 32'd0, 32'd1500};
	localparam logic        PULSES [4] = '{1'b1, 1'b0, 1'b1, 1'b1};
	localparam int unsigned PHASE_ITEMS = 100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [31:0] now_ms;
	logic [1:0]  new_state;
	logic [2:0]  led_select;
	logic [7:0]  red_in;
	logic [7:0]  green_in;
	logic [7:0]  blue_in;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  led_action;
	logic [2:0]  led_target;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic [1:0]  buzzer_action;
	logic [9:0]  tone_hz;

	panel_req_t cur_req = '0;
	logic       cur_typed = 1'b0;
	res_t       cur_result = '0;
	logic       burst = 1'b0;
	logic [31:0] panel_ms = 32'hFFFF_F000;
	res_t       due_results [$];
	int unsigned mismatches = 0;

	// Predicted panel state and registers, at their reset values
	logic [31:0] exit_delay = EXIT_DELAY_RST;
	logic        pulse_en = 1'b1;
	mode_t       sys_mode = MODE_DISARMED;
	logic [31:0] led_mark = '0;
	logic        bright = 1'b1;
	bz_mode_t    bz_mode = BZ_OFF;
	logic        bz_on = 1'b0;
	logic [31:0] bz_mark = '0;
	logic [31:0] chirp_t0 = '0;
	logic        siren_hi = 1'b1;

	assign req_type   = cur_req.kind;
	assign now_ms     = cur_req.now;
	assign new_state  = cur_req.state;
	assign led_select = cur_req.sel;
	assign red_in     = cur_req.colour.red;
	assign green_in   = cur_req.colour.green;
	assign blue_in    = cur_req.colour.blue;

	alarm_annunciator_sequencer dut (.*);

	always #1 clk = ~clk;

	// Work out the LED and buzzer changes of one request and advance the state
	function automatic res_t annunciate(input panel_req_t r);
		res_t        o;
		logic [31:0] el;
		logic [9:0]  phase;
		o = '0;
		case (r.kind)
			REQ_APPLY: begin
				sys_mode = r.state;
				bright = 1'b1;
				led_mark = r.now;
				bz_on = 1'b0;
				bz_mode = BZ_OFF;
				o.led_action = LED_ALL;
				o.buzzer_action = BZA_SILENCE;
				case (r.state)
					MODE_DISARMED: o.colour = COL_DISARMED;
					MODE_ARMED: o.colour = COL_ARMED;
					MODE_PREALARM: begin
						o.colour = COL_PRE;
						o.buzzer_action = BZA_TONE;
						o.tone_hz = TONE_ENTRY;
						bz_mode = BZ_ENTRY;
						bz_mark = r.now;
					end
					default: begin
						o.colour = COL_TRIG;
						o.buzzer_action = BZA_TONE;
						o.tone_hz = TONE_HIGH;
						bz_on = 1'b1;
						bz_mode = BZ_SIREN;
						bz_mark = r.now;
						siren_hi = 1'b1;
					end
				endcase
			end
			REQ_CHIRP: begin
				chirp_t0 = r.now;
				bz_mode = BZ_CHIRP;
				bz_on = 1'b1;
				o.buzzer_action = BZA_TONE;
				o.tone_hz = TONE_CHIRP;
			end
			REQ_LED: begin
				if (r.sel < LED_COUNT_DEF) begin
					o.led_action = LED_ONE;
					o.led_target = r.sel;
					o.colour = r.colour;
				end
			end
			default: begin
				// pulse the strip in the alarm states
				el = r.now - led_mark;
				if (pulse_en && (sys_mode == MODE_PREALARM || sys_mode == MODE_TRIGGERED)
						&& el >= LED_PULSE_MS) begin
					led_mark = r.now;
					bright = ~bright;
					o.led_action = LED_ALL;
					if (sys_mode == MODE_PREALARM) begin
						o.colour = bright ? COL_PRE : COL_PRE_DIM;
					end else begin
						o.colour = bright ? COL_TRIG : COL_TRIG_DIM;
					end
				end
				// advance the buzzer sequence
				el = r.now - ((bz_mode == BZ_CHIRP) ? chirp_t0 : bz_mark);
				case (bz_mode)
					BZ_ENTRY: begin
						if (el >= ENTRY_BEEP_MS) begin
							o.buzzer_action = BZA_SILENCE;
							bz_mode = BZ_OFF;
							bz_on = 1'b0;
						end
					end
					BZ_CHIRP: begin
						phase = 10'(el % CHIRP_PERIOD_MS);
						if (el >= exit_delay) begin
							o.buzzer_action = BZA_SILENCE;
							bz_mode = BZ_OFF;
							bz_on = 1'b0;
						end else if (phase < CHIRP_ON_MS && !bz_on) begin
							o.buzzer_action = BZA_TONE;
							o.tone_hz = TONE_CHIRP;
							bz_on = 1'b1;
						end else if (phase >= CHIRP_ON_MS && bz_on) begin
							o.buzzer_action = BZA_SILENCE;
							bz_on = 1'b0;
						end
					end
					BZ_SIREN: begin
						if (el >= SIREN_SWAP_MS) begin
							bz_mark = r.now;
							siren_hi = ~siren_hi;
							o.buzzer_action = BZA_TONE;
							o.tone_hz = siren_hi ? TONE_HIGH : TONE_LOW;
						end
					end
					default: ;
				endcase
			end
		endcase
		return o;
	endfunction

	// Random request with the panel clock moving on, mostly in small steps
	function automatic panel_req_t next_request();
		panel_req_t  r;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 3) begin
			panel_ms = $urandom;
		end else if (pick < 18) begin
			panel_ms += $urandom_range(1200, 250);
		end else if (pick < 93) begin
			panel_ms += $urandom_range(250, 1);
		end
		pick = $urandom_range(99);
		if (pick < 55) begin
			r.kind = REQ_TICK;
		end else if (pick < 70) begin
			r.kind = REQ_APPLY;
		end else if (pick < 80) begin
			r.kind = REQ_CHIRP;
		end else begin
			r.kind = REQ_LED;
		end
		r.now = panel_ms;
		r.state = mode_t'($urandom_range(3));
		r.sel = 3'($urandom_range(7));
		r.colour = rgb_t'(24'($urandom));
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Present one request and hold it until it is accepted
	task automatic present(input panel_req_t r, input logic typed, input res_t result);
		@(negedge clk);
		while (!burst && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cur_req <= r;
		cur_typed <= typed;
		cur_result <= result;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Drop valid and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stall the result side at random, never during a burst
	always @(negedge clk) begin
		out_ready <= burst || ($urandom_range(99) >= 33);
	end

	// Track register writes, check results, queue the expected result of each request
	always @(posedge clk) begin : watch
		res_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_EXIT_DELAY) begin
					exit_delay = cfg_data;
				end else if (cfg_index == CFG_PULSE_EN) begin
					pulse_en = cfg_data[0];
				end
			end
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: expected no result, got led %0d/%0d %0d,%0d,%0d bz %0d/%0d",
						$time, led_action, led_target, red_out, green_out, blue_out,
						buzzer_action, tone_hz);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("led_action", want.led_action, led_action);
					check_field("led_target", want.led_target, led_target);
					check_field("red_out", want.colour.red, red_out);
					check_field("green_out", want.colour.green, green_out);
					check_field("blue_out", want.colour.blue, blue_out);
					check_field("buzzer_action", want.buzzer_action, buzzer_action);
					check_field("tone_hz", want.tone_hz, tone_hz);
				end
			end
			if (in_valid && in_ready) begin
				want = annunciate(cur_req);
				due_results.push_back(cur_typed ? cur_result : want);
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed plan
		foreach (PLAN[i]) begin
			if (PLAN[i].cfg) begin
				settle();
				write_reg(PLAN[i].sel[CFG_IDX_BITS-1:0], PLAN[i].word);
			end else begin
				present('{PLAN[i].kind, PLAN[i].word, PLAN[i].state, PLAN[i].sel,
					PLAN[i].colour}, PLAN[i].typed, PLAN[i].result);
			end
		end

		// random phases, one register setting each; the second holds a burst
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			write_reg(CFG_EXIT_DELAY, DELAYS[ph]);
			write_reg(CFG_PULSE_EN, 32'(PULSES[ph]));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				burst = (ph == 1) && (n >= 30) && (n < 80);
				present(next_request(), 1'b0, QUIET);
			end
		end
		burst = 1'b0;

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#400_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== alarm_annunciator_sequencer.f =====
src/aas_pkg.sv
src/alarm_annunciator_sequencer.sv
tb/tb.sv
